### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define CSDM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("csdm assertion failed");

// Clocked assertion that also watches reset cycles.
`define CSDM_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("csdm reset assertion failed");

`endif

### rtl/csdm_pkg.sv
`timescale 1ns / 1ps
package csdm_pkg;

   // default configuration
   localparam int COORD_BITS_DEF     = 16;
   localparam int ROTATION_STEPS_DEF = 16;

   // angle quotient format and derived widths
   localparam int ANGLE_FRAC = 16;
   localparam int QUOT_BITS  = ANGLE_FRAC + 1;
   localparam int T_W        = ANGLE_FRAC + 4;

   // CORDIC datapath widths (Q2.30 with headroom)
   localparam int CW = 34;
   localparam int ZW = 33;

   localparam logic [29:0] QUARTER_PI_Q30  = 30'd843314857;
   localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

   localparam logic signed [15:0] OUT_MAX = 16'sh7fff;
   localparam logic signed [15:0] OUT_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      SEC_RIGHT  = 2'd0,
      SEC_TOP    = 2'd1,
      SEC_LEFT   = 2'd2,
      SEC_BOTTOM = 2'd3
   } sector_type;

   typedef enum logic [1:0] {
      QUAD_E = 2'd0,
      QUAD_N = 2'd1,
      QUAD_W = 2'd2,
      QUAD_S = 2'd3
   } quad_type;

   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       origin;
   } div_side_type;

   typedef struct packed {
      logic [15:0] square_u;
      logic [15:0] square_v;
   } req_type;

   typedef struct packed {
      logic signed [15:0] disk_x;
      logic signed [15:0] disk_y;
   } rsp_type;

   // arctangent of 2^-idx, Q2.30, truncated (idx 0 rounded)
   function automatic logic [29:0] atan_q30(input int unsigned idx);
      logic [29:0] val;
      case (idx)
         0: val = 30'd843314857;
         1: val = 30'd497837829;
         2: val = 30'd263043836;
         3: val = 30'd133525158;
         4: val = 30'd67021686;
         5: val = 30'd33543515;
         6: val = 30'd16775850;
         7: val = 30'd8388437;
         8: val = 30'd4194282;
         9: val = 30'd2097149;
         10: val = 30'd1048575;
         11: val = 30'd524287;
         12: val = 30'd262143;
         13: val = 30'd131071;
         14: val = 30'd65535;
         15: val = 30'd32767;
         16: val = 30'd16383;
         17: val = 30'd8191;
         18: val = 30'd4095;
         19: val = 30'd2047;
         20: val = 30'd1023;
         21: val = 30'd511;
         22: val = 30'd255;
         23: val = 30'd127;
         24: val = 30'd63;
         25: val = 30'd31;
         26: val = 30'd15;
         27: val = 30'd7;
         28: val = 30'd3;
         29: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

### rtl/csdm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, num <= den.
module csdm_div #(
   parameter int COORD_BITS = csdm_pkg::COORD_BITS_DEF,
   parameter int SIDE_W     = 4
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [COORD_BITS-1:0] num_mag,
   input  logic [COORD_BITS-1:0] den_mag,
   input  logic [SIDE_W-1:0]     side_in,
   output logic [csdm_pkg::QUOT_BITS-1:0] quot,
   output logic [COORD_BITS-1:0] den_out,
   output logic [SIDE_W-1:0]     side_out
);

   localparam int CB = COORD_BITS;
   localparam int NQ = csdm_pkg::QUOT_BITS;

   logic [CB:0]       rem_ff  [NQ-1];
   logic [NQ-1:0]     quot_ff [NQ];
   logic [CB-1:0]     den_ff  [NQ];
   logic [SIDE_W-1:0] side_ff [NQ];

   for (genvar j = 0; j < NQ; j++) begin : g_stage
      logic [CB:0]       rem_cur;
      logic [NQ-1:0]     quot_cur;
      logic [CB-1:0]     den_cur;
      logic [SIDE_W-1:0] side_cur;
      logic              ge;
      logic [CB:0]       rem_in;
      logic [NQ-1:0]     quot_in;

      if (j == 0) begin : g_first
         assign rem_cur  = {1'b0, num_mag};
         assign quot_cur = '0;
         assign den_cur  = den_mag;
         assign side_cur = side_in;
      end else begin : g_next
         assign rem_cur  = {rem_ff[j-1][CB-1:0], 1'b0};
         assign quot_cur = quot_ff[j-1];
         assign den_cur  = den_ff[j-1];
         assign side_cur = side_ff[j-1];
      end

      // compare and subtract, shift the decision into the quotient
      assign ge      = rem_cur >= {1'b0, den_cur};
      assign rem_in  = ge ? rem_cur - {1'b0, den_cur} : rem_cur;
      assign quot_in = {quot_cur[NQ-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[j] <= quot_in;
            den_ff[j]  <= den_cur;
            side_ff[j] <= side_cur;
         end
      end

      if (j < NQ - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
            end
         end
      end
   end

   assign quot     = quot_ff[NQ-1];
   assign den_out  = den_ff[NQ-1];
   assign side_out = side_ff[NQ-1];

endmodule

### rtl/csdm_cordic.sv
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
module csdm_cordic #(
   parameter int ROTATION_STEPS = csdm_pkg::ROTATION_STEPS_DEF,
   parameter int SIDE_W         = 18
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [csdm_pkg::ZW-1:0]    angle,
   input  logic [SIDE_W-1:0]                 side_in,
   output logic signed [csdm_pkg::CW-1:0]    cos_out,
   output logic signed [csdm_pkg::CW-1:0]    sin_out,
   output logic [SIDE_W-1:0]                 side_out
);

   localparam int CW = csdm_pkg::CW;
   localparam int ZW = csdm_pkg::ZW;
   localparam int NS = ROTATION_STEPS;

   logic signed [CW-1:0] cx_ff   [NS];
   logic signed [CW-1:0] cy_ff   [NS];
   logic signed [ZW-1:0] cz_ff   [NS-1];
   logic [SIDE_W-1:0]    side_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_rot
      logic signed [CW-1:0] cx_cur, cy_cur, cx_in, cy_in;
      logic signed [ZW-1:0] cz_cur, cz_in, step;
      logic [SIDE_W-1:0]    side_cur;

      if (i == 0) begin : g_first
         assign cx_cur   = signed'(CW'(csdm_pkg::CORDIC_GAIN_Q30));
         assign cy_cur   = '0;
         assign cz_cur   = angle;
         assign side_cur = side_in;
      end else begin : g_next
         assign cx_cur   = cx_ff[i-1];
         assign cy_cur   = cy_ff[i-1];
         assign cz_cur   = cz_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      // rotate toward zero residual angle
      assign step = signed'(ZW'(csdm_pkg::atan_q30(i)));
      always_comb begin
         if (!cz_cur[ZW-1]) begin
            cx_in = cx_cur - (cy_cur >>> i);
            cy_in = cy_cur + (cx_cur >>> i);
            cz_in = cz_cur - step;
         end else begin
            cx_in = cx_cur + (cy_cur >>> i);
            cy_in = cy_cur - (cx_cur >>> i);
            cz_in = cz_cur + step;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i]   <= cx_in;
            cy_ff[i]   <= cy_in;
            side_ff[i] <= side_cur;
         end
      end

      if (i < NS - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) begin
               cz_ff[i] <= cz_in;
            end
         end
      end
   end

   assign cos_out  = cx_ff[NS-1];
   assign sin_out  = cy_ff[NS-1];
   assign side_out = side_ff[NS-1];

endmodule

### rtl/concentric_square_to_disk_map_top.sv
`timescale 1ns / 1ps
// Concentric square-to-disk map: each (u,v) sample in unsigned Q0.16 becomes a
// disk point (x,y) in signed Q1.15, saturated to [-1,+1). The block is a single
// pipeline of ROTATION_STEPS + 23 register stages (39 at the defaults) and
// accepts one sample every cycle while the output is not stalled; the stages
// include the 17-stage quotient divider and one CORDIC micro-rotation per
// stage. A stalled result holds the whole pipeline, so req_ready falls only
// while rsp_valid waits on rsp_ready. The origin maps to (0,0).
module concentric_square_to_disk_map_top #(
   parameter int COORD_BITS     = csdm_pkg::COORD_BITS_DEF,
   parameter int ROTATION_STEPS = csdm_pkg::ROTATION_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  csdm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output csdm_pkg::rsp_type rsp_payload
);

   localparam int CB      = COORD_BITS;
   localparam int NQ      = csdm_pkg::QUOT_BITS;
   localparam int AF      = csdm_pkg::ANGLE_FRAC;
   localparam int TW      = csdm_pkg::T_W;
   localparam int CW      = csdm_pkg::CW;
   localparam int ZW      = csdm_pkg::ZW;
   localparam int DEPTH   = ROTATION_STEPS + NQ + 6;
   localparam int SH      = CB + 14;
   localparam int DSIDE_W = $bits(csdm_pkg::div_side_type);
   localparam int CSIDE_W = 2 + CB;

   // valid chain
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             en;

   // decode
   logic [CB-1:0]          cu, cv;
   logic signed [CB:0]     x, y, num, den;
   logic signed [CB+1:0]   sxy;
   logic [CB:0]            num_abs, den_abs;
   csdm_pkg::sector_type   sec;
   logic [CB-1:0]          an_ff, ad_ff;
   csdm_pkg::div_side_type dside_ff;

   // divider outputs
   logic [NQ-1:0]          quot;
   logic [CB-1:0]          rad_d;
   logic [DSIDE_W-1:0]     dside_vec;
   csdm_pkg::div_side_type dside;

   // angle reduction
   logic signed [NQ:0]   rs;
   logic signed [TW-1:0] offs, tval;
   logic [TW:0]          tk;
   logic [2:0]           kfull;
   logic signed [TW:0]   tred;
   logic sub;
   logic signed [NQ:0]   tr_ff;
   csdm_pkg::quad_type   quad_t_ff;
   logic [CB-1:0]        rad_t_ff;

   // radian conversion
   logic [NQ-1:0]        tmag;
   logic [NQ+29:0]       aprod;
   logic [30:0]          am_ff;
   logic                 aneg_ff;
   csdm_pkg::quad_type   quad_m_ff;
   logic [CB-1:0]        rad_m_ff;
   logic signed [ZW-1:0] z0;

   // cordic outputs
   logic signed [CW-1:0] ccos, csin, c_sel, s_sel;
   logic [CSIDE_W-1:0]   cside;
   csdm_pkg::quad_type   cquad;

   // magnitude, product, output
   logic [31:0]        cm_ff, sm_ff;
   logic               cneg_ff, sneg_ff, pxneg_ff, pyneg_ff;
   logic [CB-1:0]      rad_s_ff;
   logic [CB+31:0]     px_ff, py_ff;
   csdm_pkg::rsp_type  out_ff;

   // round half away from zero to Q1.15 and saturate
   function automatic logic signed [15:0] scale_sat(input logic [CB+31:0] p,
                                                    input logic neg);
      logic [CB+32:0]    sum;
      logic [CB+32-SH:0] m;
      logic signed [15:0] r;
      sum = (CB+33)'(p) + ((CB+33)'(1) << (SH - 1));
      m   = sum[CB+32:SH];
      if (!neg) begin
         r = (m > (CB+33-SH)'(32767)) ? csdm_pkg::OUT_MAX : signed'(m[15:0]);
      end else begin
         r = (m > (CB+33-SH)'(32767)) ? csdm_pkg::OUT_MIN : -signed'(m[15:0]);
      end
      return r;
   endfunction

   // advance everything unless the output is held
   assign en        = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // take the low COORD_BITS of each coordinate, or zero-extend past 16 bits
   if (CB <= 16) begin : g_narrow
      assign cu = req_payload.square_u[CB-1:0];
      assign cv = req_payload.square_v[CB-1:0];
   end else begin : g_wide
      assign cu = {{(CB-16){1'b0}}, req_payload.square_u};
      assign cv = {{(CB-16){1'b0}}, req_payload.square_v};
   end

   // center coordinates and pick the sector
   assign x   = signed'({1'b0, cu}) - signed'((CB+1)'(64'd1 << (CB - 1)));
   assign y   = signed'({1'b0, cv}) - signed'((CB+1)'(64'd1 << (CB - 1)));
   assign sxy = (CB+2)'(x) + (CB+2)'(y);

   always_comb begin
      if (sxy > 0) begin
         if (x > y) begin
            sec = csdm_pkg::SEC_RIGHT;
            num = y;
            den = x;
         end else begin
            sec = csdm_pkg::SEC_TOP;
            num = x;
            den = y;
         end
      end else if (x < y) begin
         sec = csdm_pkg::SEC_LEFT;
         num = y;
         den = x;
      end else begin
         sec = csdm_pkg::SEC_BOTTOM;
         num = x;
         den = y;
      end
      num_abs = num[CB] ? -num : num;
      den_abs = den[CB] ? -den : den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_ff           <= num_abs[CB-1:0];
         ad_ff           <= den_abs[CB-1:0];
         dside_ff.sector <= sec;
         dside_ff.neg    <= num[CB] ^ den[CB];
         dside_ff.origin <= (x == '0) && (y == '0);
      end
   end

   csdm_div #(
      .COORD_BITS (CB),
      .SIDE_W     (DSIDE_W)
   ) u_div (
      .clock    (clock),
      .en       (en),
      .num_mag  (an_ff),
      .den_mag  (ad_ff),
      .side_in  (dside_ff),
      .quot     (quot),
      .den_out  (rad_d),
      .side_out (dside_vec)
   );

   assign dside = csdm_pkg::div_side_type'(dside_vec);

   // build the angle in eighths of a turn and fold it into [-1,1)
   assign sub  = (dside.sector == csdm_pkg::SEC_TOP) || (dside.sector == csdm_pkg::SEC_BOTTOM);
   assign rs   = dside.neg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
   assign offs = signed'({1'b0, dside.sector, 1'b0, {AF{1'b0}}});
   assign tval = dside.origin ? '0 : (sub ? offs - TW'(rs) : offs + TW'(rs));
   assign tk    = (TW+1)'(tval) + ((TW+1)'(1) << AF);
   assign kfull = tk[TW-1:AF+1];
   assign tred  = (TW+1)'(tval) - signed'({1'b0, kfull, {(AF+1){1'b0}}});

   always_ff @(posedge clock) begin
      if (en) begin
         tr_ff     <= tred[NQ:0];
         quad_t_ff <= csdm_pkg::quad_type'(kfull[1:0]);
         rad_t_ff  <= rad_d;
      end
   end

   // scale by pi/4 into Q2.30 radians
   assign tmag  = NQ'(tr_ff[NQ] ? -tr_ff : tr_ff);
   assign aprod = (NQ+30)'(tmag) * (NQ+30)'(csdm_pkg::QUARTER_PI_Q30);

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff     <= aprod[NQ+29:AF];
         aneg_ff   <= tr_ff[NQ];
         quad_m_ff <= quad_t_ff;
         rad_m_ff  <= rad_t_ff;
      end
   end

   assign z0 = aneg_ff ? -signed'({2'b0, am_ff}) : signed'({2'b0, am_ff});

   csdm_cordic #(
      .ROTATION_STEPS (ROTATION_STEPS),
      .SIDE_W         (CSIDE_W)
   ) u_cordic (
      .clock    (clock),
      .en       (en),
      .angle    (z0),
      .side_in  ({quad_m_ff, rad_m_ff}),
      .cos_out  (ccos),
      .sin_out  (csin),
      .side_out (cside)
   );

   // apply the quadrant by swapping and negating
   assign cquad = csdm_pkg::quad_type'(cside[CSIDE_W-1:CB]);

   always_comb begin
      case (cquad)
         csdm_pkg::QUAD_N: begin
            c_sel = -csin;
            s_sel = ccos;
         end
         csdm_pkg::QUAD_W: begin
            c_sel = -ccos;
            s_sel = -csin;
         end
         csdm_pkg::QUAD_S: begin
            c_sel = csin;
            s_sel = -ccos;
         end
         default: begin
            c_sel = ccos;
            s_sel = csin;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cm_ff    <= 32'(c_sel[CW-1] ? -c_sel : c_sel);
         sm_ff    <= 32'(s_sel[CW-1] ? -s_sel : s_sel);
         cneg_ff  <= c_sel[CW-1];
         sneg_ff  <= s_sel[CW-1];
         rad_s_ff <= cside[CB-1:0];
      end
   end

   // radius times trig magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= (CB+32)'(rad_s_ff) * (CB+32)'(cm_ff);
         py_ff    <= (CB+32)'(rad_s_ff) * (CB+32)'(sm_ff);
         pxneg_ff <= cneg_ff;
         pyneg_ff <= sneg_ff;
      end
   end

   // round, saturate and hold the result
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.disk_x <= scale_sat(px_ff, pxneg_ff);
         out_ff.disk_y <= scale_sat(py_ff, pyneg_ff);
      end
   end

   assign rsp_valid   = vld_ff[DEPTH-1];
   assign rsp_payload = out_ff;

endmodule

### rtl/csdm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks for the disk map pipeline.
module csdm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input csdm_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input csdm_pkg::rsp_type rsp_payload
);

   // a held result stays put until its transfer
   `CSDM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // the pipe only stalls while a result waits at the output
   `CSDM_ASSERT(a_ready_flow, !rsp_valid || rsp_ready |-> req_ready)

   // reset drains the pipeline
   `CSDM_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind concentric_square_to_disk_map_top csdm_checker u_csdm_checker (.*);
